FILE: src/assert_macros.svh
// Assertion macros for the great-circle distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on the rising clock, off while reset is held.
`define GCDIST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gcdist assertion failed");
// Check a property on the rising clock, also during reset.
`define GCDIST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("gcdist assertion failed");
`else
`define GCDIST_ASSERT(lbl, prop)
`define GCDIST_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: src/gcdist_pkg.sv
// Constants and tables shared by the great-circle distance modules.
`default_nettype none
package gcdist_pkg;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 31;
  localparam int RAD_STAGES   = 5;
  localparam int POST_STAGES  = 3;
  localparam int PIPE_DEPTH   = 1 + RAD_STAGES + CORDIC_STEPS + POST_STAGES
                                + SQRT_STEPS + CORDIC_STEPS + 1;

  localparam int CW = 34;  // CORDIC datapath width

  localparam logic signed [31:0] HALF_TURN = 32'sd188743680;
  localparam logic signed [31:0] FULL_TURN = 32'sd377487360;
  localparam logic [27:0] QUARTER_TURN     = 28'd94371840;

  localparam logic [16:0] PI_LO   = 17'h16A89;  // low 17 bits of pi * 2^32
  localparam logic [16:0] PI_HI   = 17'h1921F;  // high 17 bits of pi * 2^32
  localparam logic [31:0] RECIP45 = 32'd3054198966;  // floor(2^37 / 45)

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [30:0] ONE_Q30           = 31'd1073741824;

  localparam logic [20:0] RADIUS_RESET = 21'd1630976;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };
endpackage
`default_nettype wire

FILE: src/gcdist_rad.sv
// Degree to Q30 radian conversion, rounded half away from zero, five stages.
`default_nettype none
module gcdist_rad (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic                          halve_i,
  input  wire logic                          neg_i,
  input  wire logic [27:0]                   mag_i,
  output logic signed [gcdist_pkg::CW-1:0]   angle_o
);
  logic [44:0] plo_q, phi_q;
  logic        neg1_q, neg2_q, neg3_q, neg4_q;
  logic [62:0] num_full;
  logic [36:0] num_d, num2_q, num3_q, num4_q;
  logic [49:0] rlo_q;
  logic [50:0] rhi_q;
  logic [69:0] rsum;
  logic [31:0] q0_q;
  logic [37:0] rem;
  logic [31:0] q;
  logic signed [gcdist_pkg::CW-1:0] angle_q;

  // add rounding bias and drop the power-of-two part of the divisor
  always_comb begin
    num_full = {phi_q, 17'b0} + 63'(plo_q)
               + (halve_i ? (63'd45 << 24) : (63'd45 << 23));
    num_d    = halve_i ? num_full[61:25] : num_full[60:24];
  end

  assign rsum = {1'b0, rhi_q, 18'b0} + 70'(rlo_q);

  // correct the reciprocal estimate by one remainder check
  always_comb begin
    rem = {1'b0, num4_q} - ((38'(q0_q) << 5) + (38'(q0_q) << 3)
                            + (38'(q0_q) << 2) + 38'(q0_q));
    q   = (rem >= 38'd45) ? q0_q + 32'd1 : q0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q   <= mag_i * gcdist_pkg::PI_LO;
      phi_q   <= mag_i * gcdist_pkg::PI_HI;
      neg1_q  <= neg_i;
      num2_q  <= num_d;
      neg2_q  <= neg1_q;
      rlo_q   <= num2_q[17:0] * gcdist_pkg::RECIP45;
      rhi_q   <= num2_q[36:18] * gcdist_pkg::RECIP45;
      num3_q  <= num2_q;
      neg3_q  <= neg2_q;
      q0_q    <= rsum[68:37];
      num4_q  <= num3_q;
      neg4_q  <= neg3_q;
      angle_q <= neg4_q ? -$signed({2'b0, q}) : $signed({2'b0, q});
    end
  end

  assign angle_o = angle_q;
endmodule
`default_nettype wire

FILE: src/gcdist_cordic_cell.sv
// One circular CORDIC iteration with its stage register, rotation or vectoring.
`default_nettype none
module gcdist_cordic_cell (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [4:0]                          step_i,
  input  wire logic                                vector_i,
  input  wire logic signed [gcdist_pkg::CW-1:0]    x_i,
  input  wire logic signed [gcdist_pkg::CW-1:0]    y_i,
  input  wire logic signed [gcdist_pkg::CW-1:0]    z_i,
  output logic signed [gcdist_pkg::CW-1:0]         x_o,
  output logic signed [gcdist_pkg::CW-1:0]         y_o,
  output logic signed [gcdist_pkg::CW-1:0]         z_o
);
  logic signed [gcdist_pkg::CW-1:0] dx, dy, at, x_d, y_d, z_d;
  logic signed [gcdist_pkg::CW-1:0] x_q, y_q, z_q;
  logic up;

  // pick the direction from the residual angle or from the sign of y
  always_comb begin
    dx = y_i >>> step_i;
    dy = x_i >>> step_i;
    at = $signed({4'b0, gcdist_pkg::ATAN_Q30[step_i]});
    up = vector_i ? y_i[gcdist_pkg::CW-1] : ~z_i[gcdist_pkg::CW-1];
    if (up) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - at;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule
`default_nettype wire

FILE: src/gcdist_sqrt_cell.sv
// One step of the bitwise integer square root with its stage register.
`default_nettype none
module gcdist_sqrt_cell (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [4:0]  step_i,
  input  wire logic [61:0] n_i,
  input  wire logic [61:0] res_i,
  output logic [61:0]      n_o,
  output logic [61:0]      res_o
);
  logic [61:0] bitv, trial, n_d, res_d, n_q, res_q;

  // try to take the current bit pair out of the remainder
  always_comb begin
    bitv  = 62'd1 << {step_i, 1'b0};
    trial = res_i + bitv;
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + bitv;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      res_q <= res_d;
    end
  end

  assign n_o   = n_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

FILE: src/great_circle_distance.sv
// Great-circle distance by the haversine formula: a fully pipelined chain of cells.
// Stages in order: input, conversion, rotation, product, root, vectoring and output.
// Throughput: one word per cycle; every stage is a register, the whole chain
// advances together and holds while the output word waits to be taken.
// Reset clears the valid bits of all stages and loads the radius with 6371 km.
`default_nettype none
`include "assert_macros.svh"
module great_circle_distance (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [20:0]  cfg_data_i,      // sphere_radius
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // first_latitude[27:0], first_longitude[56:28], second_latitude[84:57],
  // second_longitude[113:85], zero pad [119:114]
  input  wire logic [119:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [23:0]       m_axis_tdata     // distance[22:0], zero pad [23]
);
  localparam int CW = gcdist_pkg::CW;
  localparam int NS = gcdist_pkg::CORDIC_STEPS;
  localparam int NQ = gcdist_pkg::SQRT_STEPS;
  localparam int ND = gcdist_pkg::PIPE_DEPTH;
  localparam int FLIP_DEPTH = 1 + gcdist_pkg::RAD_STAGES + NS;
  // valid bit that travels with a_q, and with the square root outputs
  localparam int A_STAGE = FLIP_DEPTH + gcdist_pkg::POST_STAGES - 1;
  localparam int R_STAGE = A_STAGE + NQ;

  logic [20:0]   radius_q;
  logic [ND-1:0] valid_q;
  logic          pipe_en, in_hs;

  // reduce a degree difference into [-180, 180)
  function automatic logic signed [31:0] wrap_deg(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v;
    if (v >= gcdist_pkg::HALF_TURN) begin
      r = v - gcdist_pkg::FULL_TURN;
    end else if (v < -gcdist_pkg::HALF_TURN) begin
      r = v + gcdist_pkg::FULL_TURN;
    end
    return r;
  endfunction

  function automatic logic [27:0] mag28(input logic signed [31:0] v);
    logic signed [31:0] a;
    a = v[31] ? -v : v;
    return a[27:0];
  endfunction

  assign pipe_en       = ~valid_q[ND-1] | m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign in_hs         = s_axis_tvalid & pipe_en;

  // hold the radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcdist_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_data_i;
    end
  end

  // advance the valid bits with the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (pipe_en) begin
      valid_q <= {valid_q[ND-2:0], in_hs};
    end
  end

  // unpack the word, wrap the differences, fold the latitudes
  logic signed [31:0] lat1, lon1, lat2, lon2, dlat, dlon;
  logic [27:0] m_lat1, m_lat2;
  logic [27:0] mag_d [4];
  logic        neg_d [4];
  logic [1:0]  flip_d;
  logic [27:0] mag0_q [4];
  logic        neg0_q [4];
  logic [1:0]  flip_q [FLIP_DEPTH];

  always_comb begin
    lat1   = 32'(signed'(s_axis_tdata[27:0]));
    lon1   = 32'(signed'(s_axis_tdata[56:28]));
    lat2   = 32'(signed'(s_axis_tdata[84:57]));
    lon2   = 32'(signed'(s_axis_tdata[113:85]));
    dlat   = wrap_deg(lat2 - lat1);
    dlon   = wrap_deg(lon2 - lon1);
    m_lat1 = mag28(lat1);
    m_lat2 = mag28(lat2);
    flip_d[0] = m_lat1 > gcdist_pkg::QUARTER_TURN;
    flip_d[1] = m_lat2 > gcdist_pkg::QUARTER_TURN;
    mag_d[0] = mag28(dlat);
    neg_d[0] = dlat[31];
    mag_d[1] = mag28(dlon);
    neg_d[1] = dlon[31];
    mag_d[2] = flip_d[0] ? 28'(gcdist_pkg::HALF_TURN) - m_lat1 : m_lat1;
    neg_d[2] = 1'b0;
    mag_d[3] = flip_d[1] ? 28'(gcdist_pkg::HALF_TURN) - m_lat2 : m_lat2;
    neg_d[3] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        mag0_q[k] <= mag_d[k];
        neg0_q[k] <= neg_d[k];
      end
      flip_q[0] <= flip_d;
      for (int k = 1; k < FLIP_DEPTH; k++) begin
        flip_q[k] <= flip_q[k-1];
      end
    end
  end

  // convert and rotate: lanes are half dlat, half dlon, lat1, lat2
  logic signed [CW-1:0] rot_x [4][NS+1];
  logic signed [CW-1:0] rot_y [4][NS+1];
  logic signed [CW-1:0] rot_z [4][NS+1];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    gcdist_rad u_rad (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .halve_i (l < 2),
      .neg_i   (neg0_q[l]),
      .mag_i   (mag0_q[l]),
      .angle_o (rot_z[l][0])
    );
    assign rot_x[l][0] = gcdist_pkg::GAIN_Q30;
    assign rot_y[l][0] = '0;
    for (genvar i = 0; i < NS; i++) begin : g_rot
      gcdist_cordic_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (pipe_en),
        .step_i   (5'(i)),
        .vector_i (1'b0),
        .x_i      (rot_x[l][i]),
        .y_i      (rot_y[l][i]),
        .z_i      (rot_z[l][i]),
        .x_o      (rot_x[l][i+1]),
        .y_o      (rot_y[l][i+1]),
        .z_o      (rot_z[l][i+1])
      );
    end
  end

  // combine into a over three product stages
  logic signed [CW-1:0] s_lat, s_lon, c1, c2;
  logic [31:0]          ms_lat, ms_lon;
  logic signed [67:0]   cprod, tprod;
  logic [32:0]          sl_q, sn_q, sl2_q;
  logic signed [CW-1:0] cc_q;
  logic signed [35:0]   t_q;
  logic signed [36:0]   a_sum;
  logic [30:0]          a_q, b_q, a_d;

  always_comb begin
    s_lat  = rot_y[0][NS];
    s_lon  = rot_y[1][NS];
    ms_lat = 32'(s_lat[CW-1] ? -s_lat : s_lat);
    ms_lon = 32'(s_lon[CW-1] ? -s_lon : s_lon);
    c1     = flip_q[FLIP_DEPTH-1][0] ? -rot_x[2][NS] : rot_x[2][NS];
    c2     = flip_q[FLIP_DEPTH-1][1] ? -rot_x[3][NS] : rot_x[3][NS];
    cprod  = c1 * c2;
    tprod  = cc_q * $signed({1'b0, sn_q});
    a_sum  = $signed({4'b0, sl2_q}) + 37'(t_q);
    if (a_sum < 0) begin
      a_d = '0;
    end else if (a_sum > $signed({6'b0, gcdist_pkg::ONE_Q30})) begin
      a_d = gcdist_pkg::ONE_Q30;
    end else begin
      a_d = a_sum[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sl_q  <= 33'(({32'b0, ms_lat} * {32'b0, ms_lat}) >> 30);
      sn_q  <= 33'(({32'b0, ms_lon} * {32'b0, ms_lon}) >> 30);
      cc_q  <= CW'(cprod >>> 30);
      sl2_q <= sl_q;
      t_q   <= 36'(tprod >>> 30);
      a_q   <= a_d;
      b_q   <= gcdist_pkg::ONE_Q30 - a_d;
    end
  end

  // square roots of a and 1-a
  logic [61:0] sq_n [2][NQ+1];
  logic [61:0] sq_r [2][NQ+1];

  assign sq_n[0][0] = {1'b0, a_q, 30'b0};
  assign sq_n[1][0] = {1'b0, b_q, 30'b0};

  for (genvar r = 0; r < 2; r++) begin : g_root
    assign sq_r[r][0] = '0;
    for (genvar i = 0; i < NQ; i++) begin : g_step
      gcdist_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (pipe_en),
        .step_i (5'(NQ - 1 - i)),
        .n_i    (sq_n[r][i]),
        .res_i  (sq_r[r][i]),
        .n_o    (sq_n[r][i+1]),
        .res_o  (sq_r[r][i+1])
      );
    end
  end

  // vectoring chain for atan2(sqrt a, sqrt(1-a))
  logic signed [CW-1:0] vec_x [NS+1];
  logic signed [CW-1:0] vec_y [NS+1];
  logic signed [CW-1:0] vec_z [NS+1];

  assign vec_x[0] = $signed({2'b0, sq_r[1][NQ][31:0]});
  assign vec_y[0] = $signed({2'b0, sq_r[0][NQ][31:0]});
  assign vec_z[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_vec
    gcdist_cordic_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (pipe_en),
      .step_i   (5'(i)),
      .vector_i (1'b1),
      .x_i      (vec_x[i]),
      .y_i      (vec_y[i]),
      .z_i      (vec_z[i]),
      .x_o      (vec_x[i+1]),
      .y_o      (vec_y[i+1]),
      .z_o      (vec_z[i+1])
    );
  end

  // scale by the radius, round, and hold the result word
  logic [30:0] z_clamp;
  logic [52:0] dist_full;
  logic [22:0] dist_q;

  always_comb begin
    z_clamp   = vec_z[NS][CW-1] ? '0 : vec_z[NS][30:0];
    dist_full = ({32'b0, radius_q} * {22'b0, z_clamp}) + (53'd1 << 28);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dist_q <= dist_full[51:29];
    end
  end

  assign m_axis_tvalid = valid_q[ND-1];
  assign m_axis_tdata  = {1'b0, dist_q};

  `GCDIST_ASSERT(a_accept_enters, in_hs |=> valid_q[0])
  `GCDIST_ASSERT(a_stall_holds, !pipe_en |=> $stable(valid_q))
  `GCDIST_ASSERT(a_sat_range, valid_q[A_STAGE] |-> (a_q <= gcdist_pkg::ONE_Q30))
  `GCDIST_ASSERT(a_root_range, valid_q[R_STAGE] |-> (sq_r[0][NQ] <= 62'(gcdist_pkg::ONE_Q30)))
endmodule
`default_nettype wire
